// ===== rtl/hse_pkg.sv =====
// Shared types, constants and the codeword function of the Hamming(15,11) stream encoder.
package hse_pkg;

  localparam int unsigned ByteW        = 8;
  localparam int unsigned DataPerBlock = 11;
  localparam int unsigned CodePerBlock = 15;
  localparam int unsigned DataBitsW    = 10;
  localparam int unsigned DataCntW     = 4;
  localparam int unsigned OutBitsW     = 7;
  localparam int unsigned OutCntW      = 3;
  localparam int unsigned ValidW       = 4;
  localparam int unsigned MaxResults   = 3;
  localparam int unsigned ResCntW      = 2;

  typedef struct packed {
    logic [ByteW-1:0]  code_byte;
    logic [ValidW-1:0] valid_bits;
    logic              last_out;
  } result_t;

  // Builds the codeword in transmit order: position 1 lands in the top bit.
  // The first data bit of the block is d[10].
  function automatic logic [CodePerBlock-1:0] encode_block(
    input logic [DataPerBlock-1:0] d
  );
    logic p1;
    logic p2;
    logic p4;
    logic p8;
    p1 = d[10] ^ d[9] ^ d[7] ^ d[6] ^ d[4] ^ d[2] ^ d[0];
    p2 = d[10] ^ d[8] ^ d[7] ^ d[5] ^ d[4] ^ d[1] ^ d[0];
    p4 = d[9]  ^ d[8] ^ d[7] ^ d[3] ^ d[2] ^ d[1] ^ d[0];
    p8 = d[6]  ^ d[5] ^ d[4] ^ d[3] ^ d[2] ^ d[1] ^ d[0];
    return {p1, p2, d[10], p4, d[9], d[8], d[7], p8, d[6:0]};
  endfunction

endpackage

// ===== rtl/hse_in_if.sv =====
// Input channel of the Hamming(15,11) stream encoder: message bytes with an end marker.
interface hse_in_if;
  logic                      valid;
  logic                      ready;
  logic [hse_pkg::ByteW-1:0] data_byte;
  logic                      end_of_message;

  modport source (output valid, output data_byte, output end_of_message, input ready);
  modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

// ===== rtl/hse_out_if.sv =====
// Output channel of the Hamming(15,11) stream encoder: packed codeword bytes.
interface hse_out_if;
  logic                       valid;
  logic                       ready;
  logic [hse_pkg::ByteW-1:0]  code_byte;
  logic [hse_pkg::ValidW-1:0] valid_bits;
  logic                       last_out;

  modport source (output valid, output code_byte, output valid_bits, output last_out,
                  input ready);
  modport sink   (input valid, input code_byte, input valid_bits, input last_out,
                  output ready);
endinterface

// ===== rtl/hamming_15_11_stream_encoder.sv =====
// Top level of the Hamming(15,11) stream encoder.
//
// Usage: message bytes enter on in_i (valid/ready), bit 7 first. Every 11 data
// bits form one 15-bit codeword, sent in position order and packed into bytes
// on out_o, earliest bit in bit 7. A byte with end_of_message set closes the
// message: a partial data block is dropped, leftover codeword bits leave as a
// zero-padded byte with valid_bits below 8, or an empty terminator (valid_bits
// 0) is sent, and last_out marks that final result.
// The results of a byte are registered and appear on out_o in the cycle after
// its transfer. A byte yields zero to three results, which are held in a small
// result register and sent one per cycle while out_o.ready is high; the next
// byte is taken in the same cycle as the last result of the previous one
// leaves, so a byte with results holds off the next byte until all have left.
// Reset clears the bit accumulators and drops any results not yet sent.
// When the receiver stalls, the current result holds on out_o and in_i.ready
// stays low once the held results of one byte are waiting.
module hamming_15_11_stream_encoder (
  input  logic      clk_i,
  input  logic      rst_ni,
  hse_in_if.sink    in_i,
  hse_out_if.source out_o
);

  logic [hse_pkg::DataBitsW-1:0] data_bits_q, data_bits_d;
  logic [hse_pkg::DataCntW-1:0]  data_count_q, data_count_d;
  logic [hse_pkg::OutBitsW-1:0]  out_bits_q, out_bits_d;
  logic [hse_pkg::OutCntW-1:0]   out_count_q, out_count_d;

  hse_pkg::result_t              res_q [hse_pkg::MaxResults];
  hse_pkg::result_t              res_d [hse_pkg::MaxResults];
  logic [hse_pkg::ResCntW-1:0]   res_cnt_q, res_cnt_d;
  logic [hse_pkg::ResCntW-1:0]   res_idx_q, res_idx_d;

  logic                          in_take;
  logic                          out_take;
  logic                          bundle_done;

  logic [hse_pkg::DataBitsW+hse_pkg::ByteW-1:0]    joined;
  logic [hse_pkg::OutCntW-1:0]                     shamt;
  logic                                            has_block;
  logic [hse_pkg::DataPerBlock-1:0]                block;
  logic [hse_pkg::CodePerBlock-1:0]                code;
  logic [hse_pkg::OutBitsW+hse_pkg::CodePerBlock-1:0] aligned;
  logic [hse_pkg::OutBitsW-1:0]                    nxt_ob;
  logic [hse_pkg::OutCntW-1:0]                     nxt_oc;
  logic [hse_pkg::ByteW-1:0]                       flush_code;
  logic [hse_pkg::ResCntW-1:0]                     n_res;

  assign in_take     = in_i.valid && in_i.ready;
  assign out_take    = out_o.valid && out_o.ready;
  assign bundle_done = (res_cnt_q == '0) ||
                       (out_take && (res_idx_q == res_cnt_q - 2'd1));
  assign in_i.ready  = bundle_done;

  assign out_o.valid      = (res_cnt_q != '0);
  assign out_o.code_byte  = res_q[res_idx_q].code_byte;
  assign out_o.valid_bits = res_q[res_idx_q].valid_bits;
  assign out_o.last_out   = res_q[res_idx_q].last_out;

  // A block completes within this byte once three or more data bits are pending;
  // shamt is then the number of byte bits that spill into the next block.
  always_comb begin
    joined    = {data_bits_q, in_i.data_byte};
    shamt     = hse_pkg::OutCntW'(data_count_q - 4'd3);
    has_block = (data_count_q >= 4'd3);
    block     = hse_pkg::DataPerBlock'(joined >> shamt);
    code      = hse_pkg::encode_block(block);
    aligned   = {out_bits_q, code} << (3'd7 - out_count_q);
  end

  always_comb begin
    data_bits_d  = data_bits_q;
    data_count_d = data_count_q;
    out_bits_d   = out_bits_q;
    out_count_d  = out_count_q;
    res_d        = res_q;
    res_cnt_d    = res_cnt_q;
    res_idx_d    = res_idx_q;
    nxt_ob       = out_bits_q;
    nxt_oc       = out_count_q;
    n_res        = '0;
    flush_code   = '0;

    if (out_take) begin
      if (res_idx_q == res_cnt_q - 2'd1) begin
        res_cnt_d = '0;
        res_idx_d = '0;
      end else begin
        res_idx_d = res_idx_q + 2'd1;
      end
    end

    if (in_take) begin
      if (has_block) begin
        data_bits_d  = hse_pkg::DataBitsW'(in_i.data_byte & ~(8'hFF << shamt));
        data_count_d = {1'b0, shamt};
        res_d[0]     = '{code_byte: aligned[21:14],
                         valid_bits: hse_pkg::ValidW'(hse_pkg::ByteW), last_out: 1'b0};
        n_res        = 2'd1;
        if (out_count_q != '0) begin
          res_d[1] = '{code_byte: aligned[13:6],
                       valid_bits: hse_pkg::ValidW'(hse_pkg::ByteW), last_out: 1'b0};
          n_res    = 2'd2;
          nxt_oc   = out_count_q - 3'd1;
          nxt_ob   = {1'b0, aligned[5:0]} >> (3'd7 - out_count_q);
        end else begin
          nxt_oc = 3'd7;
          nxt_ob = aligned[13:7];
        end
      end else begin
        data_bits_d  = joined[hse_pkg::DataBitsW-1:0];
        data_count_d = data_count_q + 4'd8;
      end
      out_bits_d  = nxt_ob;
      out_count_d = nxt_oc;

      if (in_i.end_of_message) begin
        // With nothing pending the flush byte is all zero with count zero,
        // which is exactly the terminator.
        flush_code   = hse_pkg::ByteW'({nxt_ob, 1'b0} << (3'd7 - nxt_oc));
        res_d[n_res] = '{code_byte: flush_code, valid_bits: {1'b0, nxt_oc},
                         last_out: 1'b1};
        n_res        = n_res + 2'd1;
        data_bits_d  = '0;
        data_count_d = '0;
        out_bits_d   = '0;
        out_count_d  = '0;
      end
      res_cnt_d = n_res;
      res_idx_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_bits_q  <= '0;
      data_count_q <= '0;
      out_bits_q   <= '0;
      out_count_q  <= '0;
      res_cnt_q    <= '0;
      res_idx_q    <= '0;
    end else begin
      data_bits_q  <= data_bits_d;
      data_count_q <= data_count_d;
      out_bits_q   <= out_bits_d;
      out_count_q  <= out_count_d;
      res_cnt_q    <= res_cnt_d;
      res_idx_q    <= res_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

`ifndef SYNTHESIS
  a_short_byte_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.valid_bits != hse_pkg::ValidW'(hse_pkg::ByteW)) |-> out_o.last_out)
    else $error("partial output byte without last_out");

  a_last_is_final_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.last_out |-> (res_idx_q == res_cnt_q - 2'd1))
    else $error("last_out result is not the final held result");

  a_data_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    data_count_q <= hse_pkg::DataCntW'(hse_pkg::DataPerBlock - 1))
    else $error("data bit count beyond one block");

  a_state_cleared_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take && in_i.end_of_message |=>
      (data_count_q == '0) && (out_count_q == '0) && (out_bits_q == '0))
    else $error("state not cleared after end of message");

  a_ready_needs_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready && (res_cnt_q != '0) |-> out_take)
    else $error("input ready while held results remain");
`endif

endmodule
